### design/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    // item kinds
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_CPU_MAP = 2'd2;
    localparam logic [1:0] OP_PPU_MAP = 2'd3;

    // configuration register indexes
    localparam logic CFG_PRG_MASK = 1'b0;
    localparam logic CFG_CHR_MASK = 1'b1;

    // register write decode
    localparam logic [15:0] DECODE_MASK   = 16'hF0CF;
    localparam logic [15:0] NIBBLE_CHECK  = 16'h0FCC;
    localparam logic [15:0] ADDR_PRG_LOW  = 16'h8000;
    localparam logic [15:0] ADDR_PRG_MID  = 16'hA000;
    localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
    localparam logic [15:0] ADDR_MODE_A   = 16'h9002;
    localparam logic [15:0] ADDR_MODE_B   = 16'h9080;
    localparam logic [3:0]  TOP_CHR_FIRST = 4'hB;
    localparam logic [3:0]  TOP_CHR_LAST  = 4'hE;
    localparam logic [3:0]  TOP_IRQ       = 4'hF;

    // irq register selects (low two address bits)
    localparam logic [1:0] IRQ_RELOAD_LO = 2'd0;
    localparam logic [1:0] IRQ_RELOAD_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL   = 2'd2;
    localparam logic [1:0] IRQ_ACK       = 2'd3;

    localparam logic [7:0] IRQ_COUNT_TOP = 8'hFF;
    localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;

    typedef logic [7:0] bank_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        bank_t [2:0]           prg;
        bank_t [CHR_SLOTS-1:0] chr;
        bank_t                 prg_mask;
        bank_t                 chr_mask;
    } bank_view_t;

    typedef struct packed {
        logic [20:0] mapped_address;
        logic        irq_line;
        logic [1:0]  mirroring;
    } result_t;

endpackage

### design/cbm_regs.sv
`timescale 1ns / 1ps

// mapper register file: bank registers, mode, mirroring and scanline irq
module cbm_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cbm_pkg::item_t      item,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    output cbm_pkg::bank_view_t view,
    output logic                irq_level_next,
    output logic [1:0]          mirror_next
);

    cbm_pkg::bank_t [2:0]                    prg_reg, prg_next;
    cbm_pkg::bank_t [cbm_pkg::CHR_SLOTS-1:0] chr_reg, chr_next;
    cbm_pkg::bank_t                          prg_mask_reg, chr_mask_reg;
    logic [7:0]                              mode_reg, mode_next;
    logic [1:0]                              mirror_reg;
    logic [7:0]                              reload_reg, reload_next;
    logic [7:0]                              count_reg, count_next;
    logic [1:0]                              arm_reg, arm_next;
    logic                                    level_reg;

    logic [15:0]                   m;
    logic [3:0]                    top;
    logic [3:0]                    top_off;
    logic [cbm_pkg::CHR_IDX_W-1:0] chr_idx;

    assign m       = item.address & cbm_pkg::DECODE_MASK;
    assign top     = m[15:12];
    assign top_off = top - cbm_pkg::TOP_CHR_FIRST;
    assign chr_idx = {top_off[1:0], m[1]};

    always_comb
    begin
        prg_next       = prg_reg;
        chr_next       = chr_reg;
        mode_next      = mode_reg;
        mirror_next    = mirror_reg;
        reload_next    = reload_reg;
        count_next     = count_reg;
        arm_next       = arm_reg;
        irq_level_next = level_reg;

        if (item.op == cbm_pkg::OP_WRITE)
        begin
            if (m == cbm_pkg::ADDR_PRG_LOW)
            begin
                if (mode_reg[1])
                    prg_next[2] = item.data;
                else
                    prg_next[0] = item.data;
            end
            else if (m == cbm_pkg::ADDR_PRG_MID)
            begin
                prg_next[1] = item.data;
            end
            else if (m == cbm_pkg::ADDR_MIRROR)
            begin
                mirror_next = item.data[1:0];
            end
            else if (m == cbm_pkg::ADDR_MODE_A || m == cbm_pkg::ADDR_MODE_B)
            begin
                mode_next = item.data;
            end
            else if (top >= cbm_pkg::TOP_CHR_FIRST && top <= cbm_pkg::TOP_CHR_LAST
                     && (m & cbm_pkg::NIBBLE_CHECK) == 16'h0000)
            begin
                // odd/even bank by bit 1, high/low nibble by bit 0
                if (m[0])
                    chr_next[chr_idx] = {item.data[3:0], chr_reg[chr_idx][3:0]};
                else
                    chr_next[chr_idx] = {chr_reg[chr_idx][7:4], item.data[3:0]};
            end
            else if (top == cbm_pkg::TOP_IRQ && (m & cbm_pkg::NIBBLE_CHECK) == 16'h0000)
            begin
                case (m[1:0])
                    cbm_pkg::IRQ_RELOAD_LO: reload_next = {reload_reg[7:4], item.data[3:0]};
                    cbm_pkg::IRQ_RELOAD_HI: reload_next = {item.data[3:0], reload_reg[3:0]};
                    cbm_pkg::IRQ_CONTROL:
                    begin
                        arm_next = item.data[1:0];
                        if (item.data[1])
                            count_next = reload_reg;
                    end
                    cbm_pkg::IRQ_ACK:       arm_next = {arm_reg[0], arm_reg[0]};
                    default:                arm_next = arm_reg;
                endcase
                irq_level_next = 1'b0;
            end
        end
        else if (item.op == cbm_pkg::OP_TICK)
        begin
            if (arm_reg[1])
            begin
                if (count_reg == cbm_pkg::IRQ_COUNT_TOP)
                begin
                    count_next     = reload_reg;
                    irq_level_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_reg[0]   <= 8'd0;
            prg_reg[1]   <= 8'd1;
            prg_reg[2]   <= 8'd254;
            for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++)
                chr_reg[i] <= 8'(i);
            prg_mask_reg <= 8'hFF;
            chr_mask_reg <= 8'hFF;
            mode_reg     <= 8'd0;
            mirror_reg   <= 2'd0;
            reload_reg   <= 8'd0;
            count_reg    <= 8'd0;
            arm_reg      <= 2'd0;
            level_reg    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                prg_reg    <= prg_next;
                chr_reg    <= chr_next;
                mode_reg   <= mode_next;
                mirror_reg <= mirror_next;
                reload_reg <= reload_next;
                count_reg  <= count_next;
                arm_reg    <= arm_next;
                level_reg  <= irq_level_next;
            end
            if (cfg_write)
            begin
                if (cfg_index == cbm_pkg::CFG_PRG_MASK)
                    prg_mask_reg <= cfg_data;
                else
                    chr_mask_reg <= cfg_data;
            end
        end
    end

    assign view.prg      = prg_reg;
    assign view.chr      = chr_reg;
    assign view.prg_mask = prg_mask_reg;
    assign view.chr_mask = chr_mask_reg;

endmodule

### design/cbm_translate.sv
`timescale 1ns / 1ps

// cpu rom and ppu pattern address translation
module cbm_translate
(
    input  cbm_pkg::item_t      item,
    input  cbm_pkg::bank_view_t view,
    output logic [20:0]         mapped_address
);

    logic [1:0]                    prg_slot;
    cbm_pkg::bank_t                prg_bank;
    logic [cbm_pkg::CHR_IDX_W-1:0] chr_slot;
    cbm_pkg::bank_t                chr_bank;
    logic [20:0]                   prg_addr;
    logic [20:0]                   chr_addr;

    assign prg_slot = item.address[14:13];
    assign chr_slot = item.address[12:10];

    always_comb
    begin
        if (prg_slot == cbm_pkg::PRG_FIXED_SLOT)
            prg_bank = view.prg_mask;
        else
            prg_bank = view.prg[prg_slot] & view.prg_mask;
    end

    assign chr_bank = view.chr[chr_slot] & view.chr_mask;
    assign prg_addr = {prg_bank, item.address[12:0]};
    assign chr_addr = {3'b000, chr_bank, item.address[9:0]};

    always_comb
    begin
        case (item.op)
            cbm_pkg::OP_CPU_MAP: mapped_address = prg_addr;
            cbm_pkg::OP_PPU_MAP: mapped_address = chr_addr;
            default:             mapped_address = 21'd0;
        endcase
    end

endmodule

### design/cartridge_bank_mapper_scanline_irq.sv
`timescale 1ns / 1ps

// Cartridge bank mapper with scanline irq. Every accepted input transaction (register
// write, scanline tick, cpu rom translate or ppu pattern translate) gives exactly one
// result transaction, in order. The block takes one item per clock unless the result channel
// stalls; each item passes through the input register, then through the bank register file and
// the translation logic into the result register; the register file read-modify-write on that
// path sets the rate. Results carry the mapped address (zero for writes and ticks), the irq
// level after the item and the current mirroring mode. The input stall follows the output
// stall only when both stages hold data. The user must write mask registers through the cfg
// port only while the block is idle; the block does not enforce this. cfg_ready is always high.

module cartridge_bank_mapper_scanline_irq
(
    input  logic        clk,
    input  logic        rst_n,

    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] address,
    input  logic [7:0]  data,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] mapped_address,
    output logic        irq_line,
    output logic [1:0]  mirroring,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    cbm_pkg::item_t      item_reg;
    logic                item_valid_reg;
    cbm_pkg::result_t    result_reg, result_next;
    logic                result_valid_reg;
    cbm_pkg::bank_view_t view;

    logic in_accept;
    logic out_free;
    logic step;

    // result register can load when empty or being drained this cycle
    assign out_free  = !result_valid_reg || !out_stall;
    assign step      = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    cbm_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .item           (item_reg),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .view           (view),
        .irq_level_next (result_next.irq_line),
        .mirror_next    (result_next.mirroring)
    );

    cbm_translate u_translate
    (
        .item           (item_reg),
        .view           (view),
        .mapped_address (result_next.mapped_address)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_accept)
            item_valid_reg <= 1'b1;
        else if (step)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= '{op: op, address: address, data: data};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step)
            result_valid_reg <= 1'b1;
        else if (!out_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    assign out_valid      = result_valid_reg;
    assign mapped_address = result_reg.mapped_address;
    assign irq_line       = result_reg.irq_line;
    assign mirroring      = result_reg.mirroring;

endmodule
